// ----- hdl/dxt5a_pkg.sv -----
package dxt5a_pkg;

   // running bounds of the current block
   typedef struct packed {
      logic [7:0] low;
      logic [7:0] high;
      logic [7:0] low_nz;
      logic [7:0] high_bf;
   } bounds_type;

   // per-pixel command to the quantizer
   typedef struct packed {
      logic start;
      logic six_mode;
      logic span_zero;
   } quant_ctrl_type;

   localparam int unsigned BLOCK_PIXELS = 16;
   localparam int unsigned CODE_WIDTH   = 3;
   localparam int unsigned INDEX_WIDTH  = BLOCK_PIXELS * CODE_WIDTH;

   localparam logic [7:0] ALPHA_ZERO = 8'd0;
   localparam logic [7:0] ALPHA_FULL = 8'd255;

   localparam logic [2:0] CODE_FLAT      = 3'd0;
   localparam logic [2:0] CODE_SIX_ZERO  = 3'd6;
   localparam logic [2:0] CODE_SIX_FULL  = 3'd7;
   localparam logic [2:0] SIX_STEP_LIMIT = 3'd5;

   // eight-value mode: quantized step to format code
   function automatic logic [2:0] code_eight(input logic [2:0] q);
      logic [2:0] c;
      case (q)
         3'd0: c = 3'd1;
         3'd1: c = 3'd7;
         3'd2: c = 3'd6;
         3'd3: c = 3'd5;
         3'd4: c = 3'd4;
         3'd5: c = 3'd3;
         3'd6: c = 3'd2;
         3'd7: c = 3'd0;
         default: c = 3'd0;
      endcase
      return c;
   endfunction

   // six-value mode: quantized step to format code
   function automatic logic [2:0] code_six(input logic [2:0] q);
      logic [2:0] c;
      case (q)
         3'd0: c = 3'd0;
         3'd1: c = 3'd2;
         3'd2: c = 3'd3;
         3'd3: c = 3'd4;
         3'd4: c = 3'd5;
         3'd5: c = 3'd1;
         default: c = 3'd1;
      endcase
      return c;
   endfunction

endpackage

// ----- hdl/dxt5_alpha_block_encoder.sv -----
// DXT5 (BC3) alpha block encoder. Feed the 16 alpha bytes of a 4x4 block in
// raster order, one word per accepted start (start high while busy is low).
// After the 16th word busy stays high through a setup state that picks the
// mode and endpoints, then through each pixel in turn in the shared quantizer
// (a load of 2*d*steps+span, then three restoring divide steps, one quotient
// bit each). The encoded block appears on the rsp_ ports for exactly one cycle
// with rsp_strobe high, in the same cycle that busy falls; the receiver cannot
// stall it, so it must take it then. A new block may begin loading in that
// same cycle.
module dxt5_alpha_block_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_alpha,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_endpoint_first,
   output logic [7:0]  rsp_endpoint_second,
   output logic [47:0] rsp_index_bits
);

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_QUANT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [3:0] count_ff, count_in;
   logic [3:0] pix_ff, pix_in;
   logic       strobe_ff, strobe_in;

   logic [7:0] store_ff [dxt5a_pkg::BLOCK_PIXELS];
   logic [dxt5a_pkg::INDEX_WIDTH-1:0] idx_ff;

   logic [7:0] lo_ff, span_ff, first_ff, second_ff;
   logic       six_ff, span_zero_ff;
   logic [7:0] lo_in, hi_in;
   logic       six_in;

   logic accept;
   logic q_busy, q_done;
   logic [2:0] q_code;

   dxt5a_pkg::bounds_type     bounds;
   dxt5a_pkg::quant_ctrl_type q_ctrl;

   assign busy   = state_ff != ST_LOAD;
   assign accept = start && !busy;

   // bounds tracker, cleared once the setup cycle has read it
   dxt5a_bounds u_bounds (
      .clock  (clock),
      .reset  (reset),
      .update (accept),
      .clear  (state_ff == ST_SETUP),
      .alpha  (req_alpha),
      .bounds (bounds)
   );

   // mode and endpoint selection from the final bounds
   always_comb begin
      six_in = bounds.low != bounds.high && bounds.low == dxt5a_pkg::ALPHA_ZERO
               && bounds.high == dxt5a_pkg::ALPHA_FULL;
      if (six_in) begin
         if (bounds.low_nz == dxt5a_pkg::ALPHA_FULL) begin
            lo_in = dxt5a_pkg::ALPHA_ZERO;
            hi_in = dxt5a_pkg::ALPHA_FULL;
         end else begin
            lo_in = bounds.low_nz;
            hi_in = bounds.high_bf;
         end
      end else begin
         lo_in = bounds.low;
         hi_in = bounds.high;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SETUP) begin
         lo_ff        <= lo_in;
         span_ff      <= hi_in - lo_in;
         span_zero_ff <= hi_in == lo_in;
         six_ff       <= six_in;
         first_ff     <= six_in ? lo_in : hi_in;
         second_ff    <= six_in ? hi_in : lo_in;
      end
   end

   // shared serial quantizer, one pixel at a time from the store head
   always_comb begin
      q_ctrl.start     = state_ff == ST_QUANT && !q_busy;
      q_ctrl.six_mode  = six_ff;
      q_ctrl.span_zero = span_zero_ff;
   end

   dxt5a_quant u_quant (
      .clock (clock),
      .reset (reset),
      .ctrl  (q_ctrl),
      .value (store_ff[0]),
      .lo    (lo_ff),
      .span  (span_ff),
      .busy  (q_busy),
      .done  (q_done),
      .code  (q_code)
   );

   // pixel shift line: loads at the tail, rotates past the quantizer
   always_ff @(posedge clock) begin
      if (accept || q_done) begin
         for (int i = 0; i < dxt5a_pkg::BLOCK_PIXELS - 1; i++) begin
            store_ff[i] <= store_ff[i+1];
         end
         store_ff[dxt5a_pkg::BLOCK_PIXELS-1] <= accept ? req_alpha : store_ff[0];
      end
   end

   // index shift line, pixel 0 ends in the low bits
   always_ff @(posedge clock) begin
      if (q_done) begin
         idx_ff <= {q_code, idx_ff[dxt5a_pkg::INDEX_WIDTH-1:dxt5a_pkg::CODE_WIDTH]};
      end
   end

   // block sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pix_in    = pix_ff;
      strobe_in = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               count_in = count_ff + 4'd1;
               if (count_ff == 4'd15) state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            pix_in   = 4'd0;
            state_in = ST_QUANT;
         end
         ST_QUANT: begin
            if (q_done) begin
               pix_in = pix_ff + 4'd1;
               if (pix_ff == 4'd15) begin
                  state_in  = ST_LOAD;
                  strobe_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         count_ff  <= 4'd0;
         pix_ff    <= 4'd0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pix_ff    <= pix_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_endpoint_first  = first_ff;
   assign rsp_endpoint_second = second_ff;
   assign rsp_index_bits      = idx_ff;

   // the 16th word always leads into setup
   a_last_word_setup: assert property (@(posedge clock) disable iff (reset)
      (accept && count_ff == 4'd15) |=> state_ff == ST_SETUP)
      else $error("sixteenth word did not start encoding");

   // a result only appears with the word counter back at block start
   a_strobe_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> count_ff == 4'd0)
      else $error("result strobe in the middle of a block");

   // one strobe per block
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // the quantizer only runs while encoding
   a_quant_in_state: assert property (@(posedge clock) disable iff (reset)
      q_busy |-> state_ff == ST_QUANT)
      else $error("quantizer active outside encoding");

endmodule

// ----- hdl/dxt5a_bounds.sv -----
module dxt5a_bounds (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   update,
   input  logic                   clear,
   input  logic [7:0]             alpha,
   output dxt5a_pkg::bounds_type  bounds
);

   dxt5a_pkg::bounds_type bounds_ff;
   dxt5a_pkg::bounds_type bounds_in;

   // clear the four bounds, or fold one alpha into them
   always_comb begin
      bounds_in = bounds_ff;
      if (clear) begin
         bounds_in.low     = dxt5a_pkg::ALPHA_FULL;
         bounds_in.high    = dxt5a_pkg::ALPHA_ZERO;
         bounds_in.low_nz  = dxt5a_pkg::ALPHA_FULL;
         bounds_in.high_bf = dxt5a_pkg::ALPHA_ZERO;
      end else if (update) begin
         if (alpha < bounds_ff.low) bounds_in.low = alpha;
         if (alpha > bounds_ff.high) bounds_in.high = alpha;
         if (alpha != dxt5a_pkg::ALPHA_ZERO && alpha < bounds_ff.low_nz) begin
            bounds_in.low_nz = alpha;
         end
         if (alpha != dxt5a_pkg::ALPHA_FULL && alpha > bounds_ff.high_bf) begin
            bounds_in.high_bf = alpha;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bounds_ff.low     <= dxt5a_pkg::ALPHA_FULL;
         bounds_ff.high    <= dxt5a_pkg::ALPHA_ZERO;
         bounds_ff.low_nz  <= dxt5a_pkg::ALPHA_FULL;
         bounds_ff.high_bf <= dxt5a_pkg::ALPHA_ZERO;
      end else begin
         bounds_ff <= bounds_in;
      end
   end

   assign bounds = bounds_ff;

endmodule

// ----- hdl/dxt5a_quant.sv -----
module dxt5a_quant (
   input  logic                       clock,
   input  logic                       reset,
   input  dxt5a_pkg::quant_ctrl_type  ctrl,
   input  logic [7:0]                 value,
   input  logic [7:0]                 lo,
   input  logic [7:0]                 span,
   output logic                       busy,
   output logic                       done,
   output logic [2:0]                 code
);

   logic        active_ff, active_in;
   logic [1:0]  step_ff, step_in;
   logic [11:0] rem_ff, rem_in;
   logic [11:0] den_ff, den_in;
   logic [1:0]  quot_ff, quot_in;
   logic        fixed_ff, fixed_in;
   logic [2:0]  fixed_code_ff, fixed_code_in;
   logic        six_ff, six_in;

   logic [7:0]  diff;
   logic [11:0] num;
   logic        ge;
   logic [2:0]  q;
   logic [2:0]  q_six;

   // numerator 2*d*steps + span, steps 5 or 7 by shifts, adds and a subtract
   always_comb begin
      diff = value - lo;
      if (ctrl.six_mode) begin
         num = {1'b0, diff, 3'b000} + {3'b000, diff, 1'b0} + {4'b0000, span};
      end else begin
         num = {diff, 4'b0000} - {3'b000, diff, 1'b0} + {4'b0000, span};
      end
   end

   // one restoring divide step per cycle
   assign ge = rem_ff >= den_ff;

   always_comb begin
      active_in     = active_ff;
      step_in       = step_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      quot_in       = quot_ff;
      fixed_in      = fixed_ff;
      fixed_code_in = fixed_code_ff;
      six_in        = six_ff;
      if (ctrl.start && !active_ff) begin
         active_in = 1'b1;
         step_in   = 2'd0;
         rem_in    = num;
         den_in    = {1'b0, span, 3'b000};
         quot_in   = 2'd0;
         six_in    = ctrl.six_mode;
         fixed_in  = 1'b1;
         if (ctrl.six_mode && value == dxt5a_pkg::ALPHA_ZERO) begin
            fixed_code_in = dxt5a_pkg::CODE_SIX_ZERO;
         end else if (ctrl.six_mode && value == dxt5a_pkg::ALPHA_FULL) begin
            fixed_code_in = dxt5a_pkg::CODE_SIX_FULL;
         end else if (ctrl.span_zero) begin
            fixed_code_in = dxt5a_pkg::CODE_FLAT;
         end else begin
            fixed_in      = 1'b0;
            fixed_code_in = dxt5a_pkg::CODE_FLAT;
         end
      end else if (active_ff) begin
         if (ge) rem_in = rem_ff - den_ff;
         den_in  = {1'b0, den_ff[11:1]};
         quot_in = {quot_ff[0], ge};
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd2) active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff   <= 2'd0;
      end else begin
         active_ff <= active_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      quot_ff       <= quot_in;
      fixed_ff      <= fixed_in;
      fixed_code_ff <= fixed_code_in;
      six_ff        <= six_in;
   end

   // final quotient bit comes straight from the last compare
   always_comb begin
      q     = {quot_ff, ge};
      q_six = (q > dxt5a_pkg::SIX_STEP_LIMIT) ? dxt5a_pkg::SIX_STEP_LIMIT : q;
      if (fixed_ff) begin
         code = fixed_code_ff;
      end else if (six_ff) begin
         code = dxt5a_pkg::code_six(q_six);
      end else begin
         code = dxt5a_pkg::code_eight(q);
      end
   end

   assign busy = active_ff;
   assign done = active_ff && step_ff == 2'd2;

   // a divide step is always preceded by an active cycle
   a_step_follows_active: assert property (@(posedge clock) disable iff (reset)
      (active_ff && step_ff != 2'd0) |-> $past(active_ff))
      else $error("quantizer step without prior active cycle");

   // a new load never lands on a running divide
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      (active_ff && !done) |=> active_ff)
      else $error("quantizer dropped a pixel mid-divide");

endmodule

// ----- tb/dxt5_alpha_block_encoder_tb.sv -----
`timescale 1ns / 1ps

module dxt5_alpha_block_encoder_tb;

   localparam int unsigned EIGHT_STEPS  = 7;
   localparam int unsigned SIX_STEPS    = 5;
   localparam int unsigned RANDOM_WORDS = 1600;
   localparam int unsigned DRAIN_CYCLES = 100;

   // quantized step to format code, one table per mode
   localparam logic [2:0] EIGHT_ORDER [0:7] = '{3'd1, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd0};
   localparam logic [2:0] SIX_ORDER [0:5] = '{3'd0, 3'd2, 3'd3, 3'd4, 3'd5, 3'd1};

   // encoded block predictor and queue of blocks still owed by the encoder
   class alpha_block_scoreboard;
      typedef struct {
         logic [7:0]                        first;
         logic [7:0]                        second;
         logic [dxt5a_pkg::INDEX_WIDTH-1:0] bits;
      } encoded_block_type;

      encoded_block_type pending_blocks[$];
      int unsigned       failures;
      logic [7:0]        pixels [dxt5a_pkg::BLOCK_PIXELS];
      int unsigned       fill;
      logic [7:0]        min_alpha;
      logic [7:0]        max_alpha;
      logic [7:0]        min_nonzero;
      logic [7:0]        max_below_full;

      function new();
         failures = 0;
         restart();
      endfunction

      function void restart();
         fill = 0;
         min_alpha = dxt5a_pkg::ALPHA_FULL;
         max_alpha = dxt5a_pkg::ALPHA_ZERO;
         min_nonzero = dxt5a_pkg::ALPHA_FULL;
         max_below_full = dxt5a_pkg::ALPHA_ZERO;
      endfunction

      // round(d * steps / span), halves up, exact
      function int unsigned round_step(int unsigned d, int unsigned steps, int unsigned span);
         return (2 * d * steps + span) / (2 * span);
      endfunction

      function encoded_block_type encode();
         encoded_block_type e;
         logic [7:0]        lo;
         logic [7:0]        hi;
         logic [7:0]        v;
         int unsigned       q;
         logic [2:0]        code;
         e.bits = '0;
         if (min_alpha == max_alpha) begin
            // flat block
            e.first = min_alpha;
            e.second = min_alpha;
         end else if (min_alpha == dxt5a_pkg::ALPHA_ZERO
                      && max_alpha == dxt5a_pkg::ALPHA_FULL) begin
            // six-value mode between the inner bounds
            lo = min_nonzero;
            hi = max_below_full;
            if (lo == dxt5a_pkg::ALPHA_FULL) begin
               lo = dxt5a_pkg::ALPHA_ZERO;
               hi = dxt5a_pkg::ALPHA_FULL;
            end
            for (int i = 0; i < dxt5a_pkg::BLOCK_PIXELS; i++) begin
               v = pixels[i];
               if (v == dxt5a_pkg::ALPHA_ZERO) begin
                  code = dxt5a_pkg::CODE_SIX_ZERO;
               end else if (v == dxt5a_pkg::ALPHA_FULL) begin
                  code = dxt5a_pkg::CODE_SIX_FULL;
               end else begin
                  q = 0;
                  if (hi > lo && v >= lo) q = round_step(32'(v - lo), SIX_STEPS, 32'(hi - lo));
                  if (q > SIX_STEPS) q = SIX_STEPS;
                  code = SIX_ORDER[q];
               end
               e.bits[dxt5a_pkg::CODE_WIDTH*i +: dxt5a_pkg::CODE_WIDTH] = code;
            end
            e.first = lo;
            e.second = hi;
         end else begin
            // eight-value mode between min and max
            lo = min_alpha;
            hi = max_alpha;
            for (int i = 0; i < dxt5a_pkg::BLOCK_PIXELS; i++) begin
               v = pixels[i];
               q = 0;
               if (v >= lo) q = round_step(32'(v - lo), EIGHT_STEPS, 32'(hi - lo));
               if (q > EIGHT_STEPS) q = EIGHT_STEPS;
               e.bits[dxt5a_pkg::CODE_WIDTH*i +: dxt5a_pkg::CODE_WIDTH] = EIGHT_ORDER[q];
            end
            e.first = hi;
            e.second = lo;
         end
         return e;
      endfunction

      // accepted alpha word
      function void note_word(logic [7:0] a);
         pixels[fill] = a;
         if (a < min_alpha) min_alpha = a;
         if (a > max_alpha) max_alpha = a;
         if (a != dxt5a_pkg::ALPHA_ZERO && a < min_nonzero) min_nonzero = a;
         if (a != dxt5a_pkg::ALPHA_FULL && a > max_below_full) max_below_full = a;
         if (fill != dxt5a_pkg::BLOCK_PIXELS - 1) begin
            fill++;
         end else begin
            pending_blocks.push_back(encode());
            restart();
         end
      endfunction

      // strobed encoded block against the oldest prediction
      function void check_block(logic [7:0] first, logic [7:0] second,
                                logic [dxt5a_pkg::INDEX_WIDTH-1:0] bits);
         encoded_block_type e;
         if (pending_blocks.size() == 0) begin
            $error("unexpected block: endpoint_first %0d endpoint_second %0d index_bits %h",
                   first, second, bits);
            failures++;
            return;
         end
         e = pending_blocks.pop_front();
         if (first !== e.first) begin
            $error("endpoint_first: expected %0d, got %0d", e.first, first);
            failures++;
         end
         if (second !== e.second) begin
            $error("endpoint_second: expected %0d, got %0d", e.second, second);
            failures++;
         end
         if (bits !== e.bits) begin
            $error("index_bits: expected %h, got %h", e.bits, bits);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [7:0]  req_alpha = 8'd0;
   logic        busy;
   logic        rsp_strobe;
   logic [7:0]  rsp_endpoint_first;
   logic [7:0]  rsp_endpoint_second;
   logic [47:0] rsp_index_bits;

   alpha_block_scoreboard sb = new();
   int unsigned idle_pct = 0;
   logic [7:0]  block_words [dxt5a_pkg::BLOCK_PIXELS];

   dxt5_alpha_block_encoder dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_alpha           (req_alpha),
      .rsp_strobe          (rsp_strobe),
      .rsp_endpoint_first  (rsp_endpoint_first),
      .rsp_endpoint_second (rsp_endpoint_second),
      .rsp_index_bits      (rsp_index_bits)
   );

   always #4 clock = ~clock;

   // watch both channels at the edge the encoder samples
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_block(rsp_endpoint_first, rsp_endpoint_second, rsp_index_bits);
         if (start && !busy) sb.note_word(req_alpha);
      end
   end

   // offer one word, idling each cycle with the current idle chance
   task automatic send_word(input logic [7:0] a);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_alpha <= 8'($urandom);
         @(posedge clock);
      end
      start <= 1'b1;
      req_alpha <= a;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_block();
      for (int i = 0; i < dxt5a_pkg::BLOCK_PIXELS; i++) send_word(block_words[i]);
   endtask

   // random block of one of several shapes
   task automatic make_random_block();
      int unsigned shape;
      int unsigned p0;
      int unsigned p1;
      int unsigned base;
      logic [7:0]  pick [4];
      shape = $urandom_range(7);
      for (int i = 0; i < dxt5a_pkg::BLOCK_PIXELS; i++) block_words[i] = 8'($urandom);
      case (shape)
         1, 2: begin
            // both extremes present, random inner values
            p0 = $urandom_range(dxt5a_pkg::BLOCK_PIXELS - 1);
            p1 = (p0 + 1 + $urandom_range(dxt5a_pkg::BLOCK_PIXELS - 2))
                 % dxt5a_pkg::BLOCK_PIXELS;
            block_words[p0] = dxt5a_pkg::ALPHA_ZERO;
            block_words[p1] = dxt5a_pkg::ALPHA_FULL;
            for (int i = 0; i < dxt5a_pkg::BLOCK_PIXELS; i++) begin
               if ($urandom_range(7) == 0) begin
                  block_words[i] = $urandom_range(1) ? dxt5a_pkg::ALPHA_FULL
                                                     : dxt5a_pkg::ALPHA_ZERO;
               end
            end
         end
         3: begin
            // flat, sometimes at an extreme
            case ($urandom_range(3))
               0: pick[0] = dxt5a_pkg::ALPHA_ZERO;
               1: pick[0] = dxt5a_pkg::ALPHA_FULL;
               default: pick[0] = 8'($urandom);
            endcase
            for (int i = 0; i < dxt5a_pkg::BLOCK_PIXELS; i++) block_words[i] = pick[0];
         end
         4: begin
            // narrow span, lots of rounding ties
            base = $urandom_range(255);
            for (int i = 0; i < dxt5a_pkg::BLOCK_PIXELS; i++) begin
               p0 = base + $urandom_range(6);
               block_words[i] = (p0 > 255) ? dxt5a_pkg::ALPHA_FULL : p0[7:0];
            end
         end
         5, 6: begin
            // a few distinct values, extremes likely
            pick[0] = dxt5a_pkg::ALPHA_ZERO;
            pick[1] = dxt5a_pkg::ALPHA_FULL;
            pick[2] = 8'($urandom);
            pick[3] = 8'($urandom);
            if (shape == 6) pick[$urandom_range(1)] = 8'($urandom);
            for (int i = 0; i < dxt5a_pkg::BLOCK_PIXELS; i++) begin
               block_words[i] = pick[$urandom_range(3)];
            end
         end
         7: begin
            // extremes with one inner value
            pick[0] = 8'($urandom_range(1, 254));
            for (int i = 0; i < dxt5a_pkg::BLOCK_PIXELS; i++) begin
               case ($urandom_range(2))
                  0: block_words[i] = dxt5a_pkg::ALPHA_ZERO;
                  1: block_words[i] = dxt5a_pkg::ALPHA_FULL;
                  default: block_words[i] = pick[0];
               endcase
            end
            block_words[0] = dxt5a_pkg::ALPHA_ZERO;
            block_words[dxt5a_pkg::BLOCK_PIXELS - 1] = dxt5a_pkg::ALPHA_FULL;
            block_words[$urandom_range(1, dxt5a_pkg::BLOCK_PIXELS - 2)] = pick[0];
         end
         default: ;
      endcase
   endtask

   initial begin
      int unsigned sent;
      int unsigned phase_len;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: flat at full alpha
      for (int i = 0; i < dxt5a_pkg::BLOCK_PIXELS; i++) block_words[i] = dxt5a_pkg::ALPHA_FULL;
      send_block();
      // only zero and full
      for (int i = 0; i < dxt5a_pkg::BLOCK_PIXELS; i++) begin
         block_words[i] = i[0] ? dxt5a_pkg::ALPHA_FULL : dxt5a_pkg::ALPHA_ZERO;
      end
      send_block();
      // zero, full and a single inner value
      for (int i = 0; i < dxt5a_pkg::BLOCK_PIXELS; i++) begin
         block_words[i] = (i % 3 == 0) ? 8'd128
                        : (i[0] ? dxt5a_pkg::ALPHA_FULL : dxt5a_pkg::ALPHA_ZERO);
      end
      send_block();
      // full ramp, six-value mode with inner bounds 17 and 238
      for (int i = 0; i < dxt5a_pkg::BLOCK_PIXELS; i++) block_words[i] = 8'(i * 17);
      send_block();
      // six-value ties: inner bounds 10 and 20
      for (int i = 0; i < dxt5a_pkg::BLOCK_PIXELS; i++) begin
         block_words[i] = (i + 8 > 20) ? 8'd20 : 8'(i + 8);
      end
      block_words[0] = dxt5a_pkg::ALPHA_ZERO;
      block_words[1] = dxt5a_pkg::ALPHA_FULL;
      send_block();
      // eight-value ties: span 14
      for (int i = 0; i < dxt5a_pkg::BLOCK_PIXELS; i++) block_words[i] = (i > 14) ? 8'd14 : 8'(i);
      send_block();

      // random blocks over four idling phases
      sent = 0;
      phase_len = RANDOM_WORDS / 4;
      while (sent < RANDOM_WORDS) begin
         case (sent / phase_len)
            0: idle_pct = 0;
            1: idle_pct = 51;
            2: idle_pct = 0;
            default: idle_pct = 33;
         endcase
         make_random_block();
         send_block();
         sent += dxt5a_pkg::BLOCK_PIXELS;
      end
      start <= 1'b0;

      // drain the last block
      while (sb.pending_blocks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0) begin
         $display("dxt5_alpha_block_encoder_tb: clean");
      end else begin
         $display("dxt5_alpha_block_encoder_tb: errors");
      end
      $finish;
   end

   // hang guard
   initial begin
      #5_000_000;
      $display("dxt5_alpha_block_encoder_tb: errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/dxt5a_pkg.sv
hdl/dxt5a_bounds.sv
hdl/dxt5a_quant.sv
hdl/dxt5_alpha_block_encoder.sv
tb/dxt5_alpha_block_encoder_tb.sv
